### sv/rbd2_pkg.sv
// rbd2_pkg: shared types and constants of the RGBA 2x2 box downsampler.
// Used by rbd2_line_store and rgba_box_downsample_2x2. No dependencies.
package rbd2_pkg;

   localparam int CHAN_BITS         = 8;
   localparam int LANE_BITS         = 9;
   localparam int NUM_LANES         = 4;
   localparam int PIXEL_BITS        = NUM_LANES * CHAN_BITS;
   localparam int WID_REG_BITS      = 12;
   localparam int HGT_BITS          = 13;
   localparam int ROW_BITS          = 12;
   localparam int HEIGHT_LIMIT      = 4096;
   localparam int SIZE_THRESHOLD    = 16;
   localparam int DEFAULT_MAX_WIDTH = 2048;
   localparam int CSR_INDEX_BITS    = 2;
   localparam int CSR_DATA_BITS     = 13;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH       = 2'd0,
      CSR_IMAGE_HEIGHT      = 2'd1,
      CSR_DOWNSAMPLE_ENABLE = 2'd2
   } csr_index_type;

   // Four 9-bit lanes: red, green, blue, alpha from lane 0 up.
   typedef logic [NUM_LANES-1:0][LANE_BITS-1:0] lanes_type;

endpackage

### sv/rgba_box_downsample_2x2.sv
// rgba_box_downsample_2x2: streaming 2x2 box filter for RGBA8 raster images.
// Depends on rbd2_pkg and rbd2_line_store.
//
// Usage:
//   req_*  : source pixels in raster order, one transfer per pixel.
//   rsp_*  : result pixels; rsp_tlast marks the final result of the image.
//   csr_*  : register writes (index 0 width, 1 height, 2 downsample enable),
//            always ready; write only while the stream is idle.
//   With enable set and width and height both above 16, one result is sent
//   for each 2x2 block, on its lower-right source pixel, each channel the
//   truncated mean of the four. Otherwise each pixel passes through.
//   An odd last column or row is dropped.
// Timing:
//   One pixel per cycle while req_tready is high. A result passes through the
//   read stage, which holds the line store read, and then the output register.
//   The line store does at most one read or one write per pixel.
// Reset:
//   Registers return to width 1, height 1, passthrough; position returns to
//   the first pixel. The line store is not cleared.
// Stall:
//   A held result sits in the output register while one more result waits
//   in the read stage; req_tready drops only when both are full.
module rgba_box_downsample_2x2 #(
   parameter int MAX_WIDTH = rbd2_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rbd2_pkg::PIXEL_BITS-1:0]     req_tdata,  // red_in, green_in, blue_in, alpha_in
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rbd2_pkg::PIXEL_BITS-1:0]     rsp_tdata,  // red_out, green_out, blue_out, alpha_out
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rbd2_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rbd2_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import rbd2_pkg::*;

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int SLOT_BITS = COL_BITS - 1;
   localparam int DEPTH     = MAX_WIDTH / 2;
   localparam int WID_BITS  = $clog2(MAX_WIDTH + 1);
   localparam int CW        = (WID_BITS > WID_REG_BITS) ? WID_BITS : WID_REG_BITS;

   // configuration
   logic [WID_BITS-1:0] eff_w_ff, eff_w_in;
   logic [HGT_BITS-1:0] eff_h_ff, eff_h_in;
   logic                enable_ff, enable_in;
   logic [WID_REG_BITS-1:0] raw_w;
   logic [HGT_BITS-1:0]     raw_h;
   logic                csr_fire;

   // position and pair state
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   lanes_type           pair_ff, pair_in;

   // read stage and output register
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_pass_ff;
   logic                s1_last_ff;
   lanes_type           s1_hsum_ff;
   logic                out_valid_ff, out_valid_in;
   logic [PIXEL_BITS-1:0] out_data_ff;
   logic                out_last_ff;

   logic                acc, s1_move;
   logic                halve, col_end, row_end, in_block_x, in_block_y, blk_last;
   logic [WID_BITS-1:0] half_w;
   logic [HGT_BITS-1:0] half_h;
   lanes_type           pix, hsum, above;
   logic                wr_en, rd_en, s1_load, s1_last_in;
   logic [SLOT_BITS-1:0] slot;
   logic [PIXEL_BITS-1:0] result;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;
   assign raw_w     = csr_wdata[WID_REG_BITS-1:0];
   assign raw_h     = csr_wdata[HGT_BITS-1:0];

   always_comb begin
      eff_w_in  = eff_w_ff;
      eff_h_in  = eff_h_ff;
      enable_in = enable_ff;
      if (csr_fire) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               if (raw_w == '0) begin
                  eff_w_in = WID_BITS'(1);
               end else if (CW'(raw_w) > CW'(MAX_WIDTH)) begin
                  eff_w_in = WID_BITS'(MAX_WIDTH);
               end else begin
                  eff_w_in = WID_BITS'(raw_w);
               end
            end
            CSR_IMAGE_HEIGHT: begin
               if (raw_h == '0) begin
                  eff_h_in = HGT_BITS'(1);
               end else if (raw_h > HGT_BITS'(HEIGHT_LIMIT)) begin
                  eff_h_in = HGT_BITS'(HEIGHT_LIMIT);
               end else begin
                  eff_h_in = raw_h;
               end
            end
            CSR_DOWNSAMPLE_ENABLE: begin
               enable_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------- position decode ----------------
   assign halve = enable_ff && (eff_w_ff > WID_BITS'(SIZE_THRESHOLD))
                            && (eff_h_ff > HGT_BITS'(SIZE_THRESHOLD));
   assign col_end    = WID_BITS'(col_ff) >= (eff_w_ff - WID_BITS'(1));
   assign row_end    = HGT_BITS'(row_ff) >= (eff_h_ff - HGT_BITS'(1));
   assign half_w     = eff_w_ff >> 1;
   assign half_h     = eff_h_ff >> 1;
   assign in_block_x = WID_BITS'(col_ff[COL_BITS-1:1]) < half_w;
   assign in_block_y = HGT_BITS'(row_ff[ROW_BITS-1:1]) < half_h;
   assign blk_last   = (WID_BITS'(col_ff[COL_BITS-1:1]) == (half_w - WID_BITS'(1)))
                    && (HGT_BITS'(row_ff[ROW_BITS-1:1]) == (half_h - HGT_BITS'(1)));
   assign slot       = col_ff[COL_BITS-1:1];

   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         pix[k]  = LANE_BITS'(req_tdata[k*CHAN_BITS +: CHAN_BITS]);
         hsum[k] = pair_ff[k] + pix[k];
      end
   end

   // ---------------- handshake ----------------
   assign s1_move    = s1_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | s1_move;
   assign acc        = req_tvalid & req_tready;

   assign wr_en   = acc & halve & col_ff[0] & in_block_x & ~row_ff[0];
   assign rd_en   = acc & halve & col_ff[0] & in_block_x & row_ff[0] & in_block_y;
   assign s1_load = acc & (~halve | rd_en);
   assign s1_last_in = halve ? blk_last : (col_end & row_end);

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      pair_in = pair_ff;
      if (acc) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
         if (halve && !col_ff[0]) begin
            pair_in = pix;
         end
      end
   end

   assign s1_valid_in  = s1_load | (s1_valid_ff & ~s1_move);
   assign out_valid_in = s1_move | (out_valid_ff & ~rsp_tready);

   // ---------------- line store ----------------
   rbd2_line_store #(
      .DEPTH(DEPTH)
   ) u_line_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(slot),
      .wr_data(hsum),
      .rd_en  (rd_en),
      .rd_addr(slot),
      .rd_data(above)
   );

   // ---------------- result ----------------
   always_comb begin
      logic [LANE_BITS:0] sum;
      for (int k = 0; k < NUM_LANES; k++) begin
         sum = {1'b0, above[k]} + {1'b0, s1_hsum_ff[k]};
         result[k*CHAN_BITS +: CHAN_BITS] = s1_pass_ff ? s1_hsum_ff[k][CHAN_BITS-1:0]
                                                       : sum[LANE_BITS:2];
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff     <= WID_BITS'(1);
         eff_h_ff     <= HGT_BITS'(1);
         enable_ff    <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         pair_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         eff_w_ff     <= eff_w_in;
         eff_h_ff     <= eff_h_in;
         enable_ff    <= enable_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pair_ff      <= pair_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_pass_ff <= ~halve;
         s1_last_ff <= s1_last_in;
         s1_hsum_ff <= halve ? hsum : pix;
      end
      if (s1_move) begin
         out_data_ff <= result;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   // ---------------- assertions ----------------
   a_no_overrun_s1: assert property (@(posedge clock) disable iff (reset)
      acc |-> (!s1_valid_ff || s1_move))
      else $error("read stage overwritten while holding a result");

   a_no_overrun_out: assert property (@(posedge clock) disable iff (reset)
      s1_move |-> (!out_valid_ff || rsp_tready))
      else $error("output register overwritten while stalled");

   a_store_one_port: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("line store read and write in one cycle");

   a_sizes_legal: assert property (@(posedge clock) disable iff (reset)
      (eff_w_ff != '0) && (eff_h_ff != '0)
      && (eff_w_ff <= WID_BITS'(MAX_WIDTH)) && (eff_h_ff <= HGT_BITS'(HEIGHT_LIMIT)))
      else $error("effective image size out of range");

   a_result_follows_read: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> (s1_valid_ff && !s1_pass_ff))
      else $error("line store read without a pending block result");

endmodule

### sv/rbd2_line_store.sv
// rbd2_line_store: single-port-write, registered-read line memory holding
// the horizontal pair sums of the last even row. Depends on rbd2_pkg.
module rbd2_line_store #(
   parameter int DEPTH = rbd2_pkg::DEFAULT_MAX_WIDTH / 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  rbd2_pkg::lanes_type      wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output rbd2_pkg::lanes_type      rd_data
);
   import rbd2_pkg::*;

   lanes_type mem [DEPTH];
   lanes_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### test/rgba_box_downsample_2x2_tb.sv
// Self-checking testbench for rgba_box_downsample_2x2: drives raster images through the
// pixel stream, predicts each result pixel in a behavioral box-filter model, and checks them.
// Depends on rbd2_pkg and the rgba_box_downsample_2x2 RTL.
`timescale 1ns / 1ps

module rgba_box_downsample_2x2_tb;
   import rbd2_pkg::*;

   localparam int MAX_W       = DEFAULT_MAX_WIDTH;
   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_PIXELS = 350;
   localparam int PARTIAL_LINE_PIXELS = 48;
   localparam int TALL_PIXELS = 64;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = 2'd3;

   typedef struct packed {
      logic [CHAN_BITS-1:0] alpha;
      logic [CHAN_BITS-1:0] blue;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] red;
   } rgba_type;

   typedef struct {
      rgba_type px;
      logic     last;
   } frame_result_type;

   typedef enum int {FILL_RANDOM, FILL_SATURATED, FILL_WHITE} fill_kind_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [PIXEL_BITS-1:0]     req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [PIXEL_BITS-1:0]     rsp_tdata;
   logic                      rsp_tlast;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   rgba_type rsp_pixel;
   assign rsp_pixel = rsp_tdata;

   rgba_box_downsample_2x2 uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Shadow registers and box-filter state
   logic [WID_REG_BITS-1:0] cfg_width  = 12'd1;
   logic [HGT_BITS-1:0]     cfg_height = 13'd1;
   logic                    cfg_enable = 1'b0;
   int        pos_col = 0;
   int        pos_row = 0;
   lanes_type pair_lanes = '0;
   lanes_type row_pairs [MAX_W/2];

   rgba_type         source_pixels[$];
   frame_result_type expected_results[$];
   frame_result_type oldest_result;
   int pushed_count   = 0;
   int accepted_count = 0;
   int checked_count  = 0;
   int error_count    = 0;

   int burst_left = 1;
   int gap_left   = 0;
   int rx_mode      = 0;
   int rx_mode_left = 0;
   int hold_cycles  = 0;
   bit hold_request = 1'b0;
   bit hold_done    = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic int eff_width();
      int w;
      w = cfg_width;
      if (w == 0) w = 1;
      if (w > MAX_W) w = MAX_W;
      return w;
   endfunction

   function automatic int eff_height();
      int h;
      h = cfg_height;
      if (h == 0) h = 1;
      if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
      return h;
   endfunction

   task automatic predict_pixel(input rgba_type pixel);
      int w, h, slot, k;
      bit col_end, row_end, halve;
      lanes_type src, hsum;
      logic [LANE_BITS:0] block_sum;
      logic [PIXEL_BITS-1:0] mean_px;
      frame_result_type res;
      w = eff_width();
      h = eff_height();
      col_end = (pos_col >= w - 1);
      row_end = (pos_row >= h - 1);
      halve = cfg_enable && (w > SIZE_THRESHOLD) && (h > SIZE_THRESHOLD);
      for (k = 0; k < NUM_LANES; k++) src[k] = {1'b0, pixel[k*CHAN_BITS +: CHAN_BITS]};
      if (!halve) begin
         res.px = pixel;
         res.last = col_end && row_end;
         expected_results.push_back(res);
      end else if (pos_col % 2 == 0) begin
         pair_lanes = src;
      end else if ((pos_col >> 1) < (w >> 1)) begin
         for (k = 0; k < NUM_LANES; k++) hsum[k] = pair_lanes[k] + src[k];
         slot = (pos_col >> 1) & (MAX_W/2 - 1);
         if (pos_row % 2 == 0) begin
            row_pairs[slot] = hsum;
         end else if ((pos_row >> 1) < (h >> 1)) begin
            for (k = 0; k < NUM_LANES; k++) begin
               block_sum = row_pairs[slot][k] + hsum[k];
               mean_px[k*CHAN_BITS +: CHAN_BITS] = block_sum[LANE_BITS:2];
            end
            res.px = mean_px;
            res.last = (pos_col == 2*(w >> 1) - 1) && (pos_row == 2*(h >> 1) - 1);
            expected_results.push_back(res);
         end
      end
      if (col_end) begin
         pos_col = 0;
         pos_row = row_end ? 0 : pos_row + 1;
      end else begin
         pos_col = pos_col + 1;
      end
   endtask

   // Pixel source: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_pixel(req_tdata);
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               req_tvalid <= 1'b0;
               gap_left--;
            end else if (source_pixels.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= source_pixels.pop_front();
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 64);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result sink: ready pattern switches between random modes; one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_request && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_cycles++;
         if (hold_cycles >= HOLD_CYCLES) hold_done = 1'b1;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(16, 200);
         end else begin
            rx_mode_left--;
         end
         case (rx_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         checked_count++;
         if (expected_results.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("%0t: result %0d unexpected: got %h last %b",
                        $time, checked_count, rsp_tdata, rsp_tlast);
         end else begin
            oldest_result = expected_results.pop_front();
            if (oldest_result.px.red !== rsp_pixel.red ||
                oldest_result.px.green !== rsp_pixel.green ||
                oldest_result.px.blue !== rsp_pixel.blue ||
                oldest_result.px.alpha !== rsp_pixel.alpha ||
                oldest_result.last !== rsp_tlast) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: result %0d expected %h last %b, got %h last %b",
                           $time, checked_count, oldest_result.px, oldest_result.last,
                           rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("rgba_box_downsample_2x2: mismatch");
      $finish;
   end

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_IMAGE_WIDTH:       cfg_width  = value[WID_REG_BITS-1:0];
         CSR_IMAGE_HEIGHT:      cfg_height = value;
         CSR_DOWNSAMPLE_ENABLE: cfg_enable = value[0];
         default: ;
      endcase
   endtask

   // Unused upper bits of the width and enable writes get random junk
   task automatic write_config(input int w, input int h, input int en);
      logic [CSR_DATA_BITS-1:0] junk;
      junk = ($urandom_range(0, 3) == 0) ? 13'h1000 : '0;
      write_reg(CSR_IMAGE_WIDTH, CSR_DATA_BITS'(w) | junk);
      write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_BITS'(h));
      junk = CSR_DATA_BITS'($urandom) & ~13'h1;
      write_reg(CSR_DOWNSAMPLE_ENABLE, junk | CSR_DATA_BITS'(en));
   endtask

   task automatic queue_pixel(input rgba_type pixel);
      source_pixels.push_back(pixel);
      pushed_count++;
   endtask

   task automatic queue_pixels(input int count, input fill_kind_type fill);
      rgba_type px;
      int i, k;
      for (i = 0; i < count; i++) begin
         case (fill)
            FILL_WHITE: px = '1;
            FILL_SATURATED:
               for (k = 0; k < NUM_LANES; k++)
                  px[k*CHAN_BITS +: CHAN_BITS] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: px = $urandom;
         endcase
         queue_pixel(px);
      end
   endtask

   // Number of pixels that bring the position counters back to the image origin
   function automatic int pixels_to_frame_end();
      int c, r, n, w, h;
      c = pos_col;
      r = pos_row;
      n = 0;
      w = eff_width();
      h = eff_height();
      while (n == 0 || c != 0 || r != 0) begin
         if (n == 0 && c == 0 && r == 0) return 0;
         n++;
         if (c >= w - 1) begin
            c = 0;
            r = (r >= h - 1) ? 0 : r + 1;
         end else begin
            c++;
         end
      end
      return n;
   endfunction

   task automatic wait_drained();
      while (accepted_count != pushed_count || expected_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic fill_kind_type pick_fill();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 7) return FILL_RANDOM;
      if (roll < 9) return FILL_SATURATED;
      return FILL_WHITE;
   endfunction

   initial begin : stimulus
      int w, h, en, kind, frames, random_pixels;
      wait (!reset);
      @(negedge clock);

      // Reset settings: 1x1 images, each pixel is the whole frame
      queue_pixel(32'h0000_0000);
      queue_pixel(32'hFFFF_FFFF);
      queue_pixel(32'h00FF_00FF);
      queue_pixel(32'hFF00_FF00);
      queue_pixel(32'h55AA_55AA);
      queue_pixel(32'hAA55_AA55);
      wait_drained();

      // Zero sizes behave as 1
      write_reg(CSR_IMAGE_WIDTH, '0);
      write_reg(CSR_IMAGE_HEIGHT, '0);
      queue_pixels(2, FILL_RANDOM);
      wait_drained();

      // Enabled but too small to halve
      write_config(3, 2, 1);
      queue_pixels(6, FILL_RANDOM);
      wait_drained();

      // Size changes in mid-image leave the counters beyond the new bounds
      write_config(4, 3, 0);
      queue_pixels(6, FILL_RANDOM);
      wait_drained();
      write_reg(CSR_IMAGE_WIDTH, 13'd2);
      queue_pixels(3, FILL_RANDOM);
      wait_drained();
      write_reg(CSR_IMAGE_HEIGHT, 13'd1);
      queue_pixels(2, FILL_RANDOM);
      wait_drained();
      queue_pixels(pixels_to_frame_end(), FILL_RANDOM);
      wait_drained();
      write_reg(CSR_UNUSED_INDEX, 13'($urandom));

      random_pixels = 0;
      while (random_pixels < RANDOM_PIXELS) begin
         kind = $urandom_range(0, 11);
         frames = 1;
         if (kind < 4) begin
            w = $urandom_range(17, 22);
            h = $urandom_range(17, 18);
            en = 1;
         end else if (kind < 8) begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 10);
            en = $urandom_range(0, 1);
            frames = $urandom_range(1, 3);
         end else if (kind == 8) begin
            w = SIZE_THRESHOLD;
            h = SIZE_THRESHOLD + 1;
            en = 1;
            if ($urandom_range(0, 1)) begin
               w = SIZE_THRESHOLD + 1;
               h = SIZE_THRESHOLD;
            end
         end else begin
            w = $urandom_range(17, 24);
            h = $urandom_range(1, 3);
            en = $urandom_range(0, 1);
            frames = $urandom_range(1, 2);
         end
         write_config(w, h, en);
         queue_pixels(w * h * frames, pick_fill());
         random_pixels += w * h * frames;
         wait_drained();
      end

      // Width clamped from all ones: part of a line, then width 1 ends the image
      write_config(12'hFFF, 1, 0);
      queue_pixels(PARTIAL_LINE_PIXELS, FILL_RANDOM);
      wait_drained();
      write_reg(CSR_IMAGE_WIDTH, 13'd1);
      queue_pixels(pixels_to_frame_end(), FILL_RANDOM);
      wait_drained();

      // Height clamped from all ones; the sink holds off for a long stretch meanwhile
      write_config(1, 13'h1FFF, 1);
      hold_request = 1'b1;
      queue_pixels(TALL_PIXELS, FILL_RANDOM);
      wait_drained();
      write_reg(CSR_IMAGE_HEIGHT, 13'd1);
      queue_pixels(pixels_to_frame_end(), FILL_RANDOM);
      wait_drained();

      // Smallest halved image, all white; bit 12 of the width write is dropped
      write_config(13'h1000 | (SIZE_THRESHOLD + 1), SIZE_THRESHOLD + 1, 1);
      queue_pixels((SIZE_THRESHOLD + 1) * (SIZE_THRESHOLD + 1), FILL_WHITE);
      wait_drained();

      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0)
         $display("rgba_box_downsample_2x2: match");
      else
         $display("rgba_box_downsample_2x2: mismatch");
      $finish;
   end

endmodule

### sim.f
sv/rbd2_pkg.sv
sv/rbd2_line_store.sv
sv/rgba_box_downsample_2x2.sv
test/rgba_box_downsample_2x2_tb.sv
